@@ design/assert_macros.svh @@
// Assertion macros for the segment allocator.
// Used by the top level only; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under a synchronous reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed: same-cycle implication");

// Next-cycle implication under a synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed: next-cycle implication");

`endif

@@ design/scsa_pkg.sv @@
// Shared types, constants and codes for the size-class segment allocator.
// Depends on nothing; every file but scsa_ram.sv and assert_macros.svh imports it.
package scsa_pkg;

   localparam int NUM_CLASSES  = 4;
   localparam int MAX_SEGMENTS = 256;

   localparam int SIZE_W  = 31;
   localparam int CNT_W   = 9;
   localparam int SEG_W   = $clog2(MAX_SEGMENTS);
   localparam int LEN_W   = $clog2(MAX_SEGMENTS + 1);
   localparam int CLASS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CALC_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
   localparam int CSR_W   = 3;

   localparam logic [CNT_W-1:0]  COUNT_LIMIT   = CNT_W'(256);
   localparam logic [SIZE_W-1:0] SIZE_A_RESET  = SIZE_W'(100000);
   localparam logic [CNT_W-1:0]  COUNT_A_RESET = CNT_W'(100);

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_GRANTED  = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_RELEASED = 2'd2,
      ST_REJECTED = 2'd3
   } status_type;

   typedef enum logic [CSR_W-1:0] {
      REG_SIZE_A  = 3'd0,
      REG_COUNT_A = 3'd1,
      REG_SIZE_B  = 3'd2,
      REG_COUNT_B = 3'd3,
      REG_SIZE_C  = 3'd4,
      REG_COUNT_C = 3'd5,
      REG_SIZE_D  = 3'd6,
      REG_COUNT_D = 3'd7
   } csr_index_type;

   typedef logic [NUM_CLASSES-1:0][SIZE_W-1:0] size_arr_type;
   typedef logic [NUM_CLASSES-1:0][CNT_W-1:0]  count_arr_type;
   typedef logic [NUM_CLASSES-1:0][LEN_W-1:0]  len_arr_type;

   // Segment number ranges of the classes
   typedef struct packed {
      len_arr_type start;
      len_arr_type len;
      len_arr_type limit;
   } layout_type;

   // Free-list RAM access from the sequencer
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [SEG_W-1:0] addr;
      logic [SEG_W-1:0] wr_data;
   } ram_req_type;

endpackage

@@ design/scsa_ram.sv @@
// Generic single-port RAM with registered read.
// Depends on nothing.
module scsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write or read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/scsa_layout.sv @@
// Class layout: effective counts and segment number ranges of each class.
// Depends on scsa_pkg.
module scsa_layout
   import scsa_pkg::*;
(
   input  count_arr_type count,
   output layout_type    layout
);

   // Clip each count, then stack classes one after another
   always_comb begin
      logic [CALC_W-1:0] next;
      logic [CALC_W-1:0] n;
      logic [CALC_W-1:0] room;
      next   = '0;
      layout = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         n = CALC_W'(count[c]);
         if (n > CALC_W'(COUNT_LIMIT)) begin
            n = CALC_W'(COUNT_LIMIT);
         end
         room = CALC_W'(MAX_SEGMENTS) - next;
         if (n > room) begin
            n = room;
         end
         layout.start[c] = LEN_W'(next);
         layout.len[c]   = LEN_W'(n);
         next            = next + n;
         layout.limit[c] = LEN_W'(next);
      end
   end

endmodule

@@ design/scsa_cmp_unit.sv @@
// Shared compare unit: request size against class size, or segment number
// against the end of a class range. Depends on scsa_pkg.
module scsa_cmp_unit
   import scsa_pkg::*;
(
   input  logic              operation,
   input  logic [SIZE_W-1:0] request_size,
   input  logic [SEG_W-1:0]  release_seg,
   input  logic [SIZE_W-1:0] class_size,
   input  logic [LEN_W-1:0]  class_limit,
   output logic              fits
);

   logic [SIZE_W:0] operand_a;
   logic [SIZE_W:0] operand_b;

   // Segment below the limit is segment + 1 at or below it
   always_comb begin
      if (operation == OP_RELEASE) begin
         operand_a = (SIZE_W+1)'(release_seg) + (SIZE_W+1)'(1);
         operand_b = (SIZE_W+1)'(class_limit);
      end else begin
         operand_a = (SIZE_W+1)'(request_size);
         operand_b = (SIZE_W+1)'(class_size);
      end
   end

   assign fits = (operand_a <= operand_b);

endmodule

@@ design/scsa_seq.sv @@
// Sequencer: walks the classes one per cycle through the shared compare
// unit, keeps list heads and free counts, drives the free-list RAM.
// Depends on scsa_pkg and scsa_cmp_unit.
module scsa_seq
   import scsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [SIZE_W-1:0] req_request_size,
   input  logic [SEG_W-1:0]  req_release_seg,
   input  logic              csr_write_enable,
   input  size_arr_type      class_size,
   input  layout_type        layout,
   input  logic [SEG_W-1:0]  ram_q,
   input  logic              valid_q,
   output ram_req_type       ram_req,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [SEG_W-1:0]  rsp_granted_segment,
   output logic [SIZE_W-1:0] rsp_granted_size
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_REBUILD,
      S_SCAN,
      S_READ
   } state_type;

   state_type            state_ff, state_in;
   logic                 op_ff, op_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [SEG_W-1:0]     seg_ff, seg_in;
   logic [CLASS_W-1:0]   cls_ff, cls_in;
   logic [SEG_W-1:0]     addr_ff, addr_in;
   logic [SIZE_W-1:0]    grant_size_ff, grant_size_in;
   len_arr_type          head_ff, head_in;
   len_arr_type          free_ff, free_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [SEG_W-1:0]     rsp_seg_ff, rsp_seg_in;
   logic [SIZE_W-1:0]    rsp_size_ff, rsp_size_in;
   logic                 fits;

   // One comparison per cycle for the class under scan
   scsa_cmp_unit u_cmp (
      .operation      (op_ff),
      .request_size   (size_ff),
      .release_seg    (seg_ff),
      .class_size     (class_size[cls_ff]),
      .class_limit    (layout.limit[cls_ff]),
      .fits           (fits)
   );

   // Next-state and datapath
   always_comb begin
      logic [LEN_W-1:0] head_next;
      logic [LEN_W:0]   pos;
      logic             last;
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      seg_in        = seg_ff;
      cls_in        = cls_ff;
      addr_in       = addr_ff;
      grant_size_in = grant_size_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_size_in   = rsp_size_ff;
      ram_req       = '0;
      last          = (cls_ff == CLASS_W'(NUM_CLASSES - 1));
      head_next     = head_ff[cls_ff] + LEN_W'(1);
      pos           = (LEN_W+1)'(head_ff[cls_ff]) + (LEN_W+1)'(free_ff[cls_ff]);
      if (pos >= (LEN_W+1)'(layout.len[cls_ff])) begin
         pos = pos - (LEN_W+1)'(layout.len[cls_ff]);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (csr_write_enable) begin
               state_in = S_REBUILD;
            end else if (start) begin
               op_in    = req_operation;
               size_in  = req_request_size;
               seg_in   = req_release_seg;
               cls_in   = '0;
               state_in = S_SCAN;
            end
         end

         // Refill every list after reset or new configuration; hold while writes go on
         S_REBUILD: begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
               head_in[c] = '0;
               free_in[c] = layout.len[c];
            end
            state_in = csr_write_enable ? S_REBUILD : S_IDLE;
         end

         S_SCAN: begin
            if (op_ff == OP_ALLOC) begin
               if (fits && (free_ff[cls_ff] != '0) && (layout.len[cls_ff] != '0)) begin
                  // Take the oldest free segment of this class
                  addr_in        = SEG_W'(layout.start[cls_ff] + head_ff[cls_ff]);
                  ram_req.rd_en  = 1'b1;
                  ram_req.addr   = addr_in;
                  head_in[cls_ff] = (head_next == layout.len[cls_ff]) ? '0 : head_next;
                  free_in[cls_ff] = free_ff[cls_ff] - LEN_W'(1);
                  grant_size_in  = class_size[cls_ff];
                  state_in       = S_READ;
               end else if (last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NO_FIT;
                  rsp_seg_in    = '0;
                  rsp_size_in   = '0;
                  state_in      = S_IDLE;
               end else begin
                  cls_in = cls_ff + CLASS_W'(1);
               end
            end else begin
               if (fits) begin
                  rsp_valid_in = 1'b1;
                  rsp_seg_in   = '0;
                  rsp_size_in  = '0;
                  state_in     = S_IDLE;
                  if ((layout.len[cls_ff] == '0) ||
                      (free_ff[cls_ff] >= layout.len[cls_ff])) begin
                     rsp_status_in = ST_REJECTED;
                  end else begin
                     // Append at the tail of the owning class
                     ram_req.wr_en   = 1'b1;
                     ram_req.addr    = SEG_W'(layout.start[cls_ff] + LEN_W'(pos));
                     ram_req.wr_data = seg_ff;
                     free_in[cls_ff] = free_ff[cls_ff] + LEN_W'(1);
                     rsp_status_in   = ST_RELEASED;
                  end
               end else if (last) begin
                  // Segment lies beyond every class
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_REJECTED;
                  rsp_seg_in    = '0;
                  rsp_size_in   = '0;
                  state_in      = S_IDLE;
               end else begin
                  cls_in = cls_ff + CLASS_W'(1);
               end
            end
         end

         // Free-list data arrives; unwritten entries hold their own index
         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_GRANTED;
            rsp_seg_in    = valid_q ? ram_q : addr_ff;
            rsp_size_in   = grant_size_ff;
            state_in      = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_REBUILD;
         cls_ff       <= '0;
         head_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cls_ff       <= cls_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      size_ff       <= size_in;
      seg_ff        <= seg_in;
      addr_ff       <= addr_in;
      grant_size_ff <= grant_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_segment = rsp_seg_ff;
   assign rsp_granted_size    = rsp_size_ff;

endmodule

@@ design/size_class_segment_allocator.sv @@
// Size-class segment allocator: takes one request while busy is low and no
// csr write is on, and returns one result per request on a one-cycle rsp_valid
// strobe that cannot be held off. A grant from class k (0 = first class) scans
// classes 0 to k and then reads the free-list RAM; a failed grant scans every
// class; a release scans up to the owning class k, or every class when the
// segment lies beyond all classes. The sequencer compares one class per cycle
// in a shared comparator. The next request is taken in the cycle the strobe
// shows. After reset the block is busy while lists are rebuilt; after csr
// writes it is busy in the rebuild state, which it enters on the first write
// of a run and leaves once the writes stop. Per-entry valid bits stand in for
// refilling the RAM, so no clearing pass runs.
// Depends on scsa_pkg, scsa_ram, scsa_layout, scsa_seq and assert_macros.svh.
`include "assert_macros.svh"

module size_class_segment_allocator
   import scsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [SIZE_W-1:0] req_request_size,
   input  logic [SEG_W-1:0]  req_release_seg,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [SEG_W-1:0]  rsp_granted_segment,
   output logic [SIZE_W-1:0] rsp_granted_size,
   input  logic              csr_write_enable,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0] csr_write_data
);

   size_arr_type            size_ff, size_in;
   count_arr_type           count_ff, count_in;
   logic [MAX_SEGMENTS-1:0] valid_ff, valid_in;
   logic                    valid_q_ff;
   layout_type              layout;
   ram_req_type             ram_req;
   logic [SEG_W-1:0]        ram_q;

   // Decode configuration writes
   always_comb begin
      size_in  = size_ff;
      count_in = count_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_SIZE_A:  size_in[0]  = csr_write_data;
            REG_COUNT_A: count_in[0] = csr_write_data[CNT_W-1:0];
            REG_SIZE_B:  size_in[1]  = csr_write_data;
            REG_COUNT_B: count_in[1] = csr_write_data[CNT_W-1:0];
            REG_SIZE_C:  size_in[2]  = csr_write_data;
            REG_COUNT_C: count_in[2] = csr_write_data[CNT_W-1:0];
            REG_SIZE_D:  size_in[3]  = csr_write_data;
            REG_COUNT_D: count_in[3] = csr_write_data[CNT_W-1:0];
         endcase
      end
   end

   // Drop all valid bits on new configuration, mark released entries
   always_comb begin
      valid_in = valid_ff;
      if (csr_write_enable) begin
         valid_in = '0;
      end else if (ram_req.wr_en) begin
         valid_in[ram_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= {{((NUM_CLASSES - 1) * SIZE_W){1'b0}}, SIZE_A_RESET};
         count_ff <= {{((NUM_CLASSES - 1) * CNT_W){1'b0}}, COUNT_A_RESET};
         valid_ff <= '0;
      end else begin
         size_ff  <= size_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      if (ram_req.rd_en) begin
         valid_q_ff <= valid_ff[ram_req.addr];
      end
   end

   scsa_layout u_layout (
      .count  (count_ff),
      .layout (layout)
   );

   scsa_ram #(
      .WIDTH (SEG_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_free_list (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .rd_en   (ram_req.rd_en),
      .addr    (ram_req.addr),
      .wr_data (ram_req.wr_data),
      .rd_data (ram_q)
   );

   scsa_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_request_size    (req_request_size),
      .req_release_seg     (req_release_seg),
      .csr_write_enable    (csr_write_enable),
      .class_size          (size_ff),
      .layout              (layout),
      .ram_q               (ram_q),
      .valid_q             (valid_q_ff),
      .ram_req             (ram_req),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_segment (rsp_granted_segment),
      .rsp_granted_size    (rsp_granted_size)
   );

   // A result only follows a cycle of work
   `ASSERT_IMPLIES(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   // Non-grant results carry zero segment and size
   `ASSERT_IMPLIES(a_zero_unless_granted, clock, reset,
      rsp_valid && (rsp_status != ST_GRANTED),
      (rsp_granted_segment == '0) && (rsp_granted_size == '0))
   // An accepted request keeps the block busy
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   // A configuration write is followed by busy with no result strobe
   `ASSERT_NEXT(a_rebuild_after_csr, clock, reset, csr_write_enable, busy && !rsp_valid)

endmodule

@@ tb/sv/tb_size_class_segment_allocator.sv @@
// Self-checking testbench for size_class_segment_allocator: keeps its own copy of the
// per-class free lists, predicts each grant and release, and checks every strobed result.
// Depends on scsa_pkg and the allocator RTL; reads no files.
module tb_size_class_segment_allocator;
   import scsa_pkg::*;

   // One predicted result of a request
   typedef struct {
      status_type      status;
      bit [SEG_W-1:0]  segment;
      bit [SIZE_W-1:0] size;
   } alloc_result_type;

   // Tracks class layout and free lists, and holds the results still owed by the block
   class segment_ledger_type;
      bit [SIZE_W-1:0]  class_size [NUM_CLASSES];
      bit [CNT_W-1:0]   count_reg [NUM_CLASSES];
      int unsigned      first_seg [NUM_CLASSES];
      int unsigned      seg_len [NUM_CLASSES];
      int unsigned      head_off [NUM_CLASSES];
      int unsigned      free_left [NUM_CLASSES];
      int unsigned      seg_total;
      bit [SEG_W-1:0]   free_ring [MAX_SEGMENTS];
      bit               held [MAX_SEGMENTS];
      alloc_result_type owed [$];
      int unsigned      failures;

      function new();
         for (int c = 0; c < NUM_CLASSES; c++) begin
            class_size[c] = '0;
            count_reg[c] = '0;
         end
         class_size[0] = SIZE_A_RESET;
         count_reg[0] = COUNT_A_RESET;
         failures = 0;
         rebuild_lists();
      endfunction

      // Lay out classes back to back and refill every list in ascending order
      function void rebuild_lists();
         int unsigned next_seg;
         int unsigned n;
         next_seg = 0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            n = count_reg[c];
            if (n > COUNT_LIMIT) n = COUNT_LIMIT;
            if (n > MAX_SEGMENTS - next_seg) n = MAX_SEGMENTS - next_seg;
            first_seg[c] = next_seg;
            seg_len[c] = n;
            head_off[c] = 0;
            free_left[c] = n;
            next_seg += n;
         end
         seg_total = next_seg;
         for (int i = 0; i < MAX_SEGMENTS; i++) begin
            free_ring[i] = SEG_W'(i);
            held[i] = 1'b0;
         end
      endfunction

      function void write_register(csr_index_type idx, bit [SIZE_W-1:0] value);
         case (idx)
            REG_SIZE_A:  class_size[0] = value;
            REG_COUNT_A: count_reg[0] = value[CNT_W-1:0];
            REG_SIZE_B:  class_size[1] = value;
            REG_COUNT_B: count_reg[1] = value[CNT_W-1:0];
            REG_SIZE_C:  class_size[2] = value;
            REG_COUNT_C: count_reg[2] = value[CNT_W-1:0];
            REG_SIZE_D:  class_size[3] = value;
            REG_COUNT_D: count_reg[3] = value[CNT_W-1:0];
         endcase
         rebuild_lists();
      endfunction

      // Apply one accepted request to the lists and queue its result
      function void note_request(op_type op, bit [SIZE_W-1:0] need, bit [SEG_W-1:0] seg);
         alloc_result_type res;
         int unsigned      slot;
         int               owner;
         bit               done;
         res.status = ST_NO_FIT;
         res.segment = '0;
         res.size = '0;
         done = 1'b0;
         owner = -1;
         if (op == OP_ALLOC) begin
            // first class in register order that fits and has a free segment
            for (int c = 0; c < NUM_CLASSES; c++) begin
               if (!done && need <= class_size[c] && free_left[c] > 0 && seg_len[c] > 0) begin
                  slot = first_seg[c] + head_off[c];
                  res.status = ST_GRANTED;
                  res.segment = free_ring[slot];
                  res.size = class_size[c];
                  head_off[c] = (head_off[c] + 1) % seg_len[c];
                  free_left[c] -= 1;
                  held[res.segment] = 1'b1;
                  done = 1'b1;
               end
            end
         end else begin
            res.status = ST_REJECTED;
            if (seg < seg_total) begin
               for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
                  if (seg < first_seg[c] + seg_len[c]) owner = c;
               end
               // append to the owning list unless it is already full
               if (owner >= 0 && seg_len[owner] > 0 && free_left[owner] < seg_len[owner]) begin
                  slot = first_seg[owner] + (head_off[owner] + free_left[owner]) % seg_len[owner];
                  free_ring[slot] = seg;
                  free_left[owner] += 1;
                  held[seg] = 1'b0;
                  res.status = ST_RELEASED;
               end
            end
         end
         owed.insert(owed.size(), res);
      endfunction

      function void report(string what, string want, string got);
         failures++;
         $display("%0t: %s expected %s actual %s", $time, what, want, got);
      endfunction

      // Compare one strobed result against the oldest prediction
      function void check_result(logic [1:0] st, logic [SEG_W-1:0] seg, logic [SIZE_W-1:0] sz);
         alloc_result_type want;
         if (owed.size() == 0) begin
            report("result with nothing owed: status", "none", $sformatf("%0d", st));
            return;
         end
         want = owed.pop_front();
         if (st !== want.status)
            report("status", want.status.name(), $sformatf("%0d", st));
         if (seg !== want.segment)
            report("granted_segment", $sformatf("%0d", want.segment), $sformatf("%0d", seg));
         if (sz !== want.size)
            report("granted_size", $sformatf("%0d", want.size), $sformatf("%0d", sz));
      endfunction

      // Random segment currently handed out, or -1 when none is
      function int held_segment();
         int found [$];
         for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (held[i]) found.insert(found.size(), i);
         end
         if (found.size() == 0) return -1;
         return found[$urandom_range(0, found.size() - 1)];
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_operation;
   logic [SIZE_W-1:0] req_request_size;
   logic [SEG_W-1:0]  req_release_seg;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [SEG_W-1:0]  rsp_granted_segment;
   logic [SIZE_W-1:0] rsp_granted_size;
   logic              csr_write_enable;
   logic [CSR_W-1:0]  csr_index;
   logic [SIZE_W-1:0] csr_write_data;

   segment_ledger_type ledger;
   bit [SIZE_W-1:0]    layout_size [NUM_CLASSES];
   bit [SIZE_W-1:0]    layout_count [NUM_CLASSES];

   size_class_segment_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_request_size    (req_request_size),
      .req_release_seg     (req_release_seg),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_segment (rsp_granted_segment),
      .rsp_granted_size    (rsp_granted_size),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Check every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         ledger.check_result(rsp_status, rsp_granted_segment, rsp_granted_size);
   end

   // Present one request and hold it until the block takes it
   task automatic send_request(op_type op, bit [SIZE_W-1:0] need, bit [SEG_W-1:0] seg);
      start <= 1'b1;
      req_operation <= op;
      req_request_size <= need;
      req_release_seg <= seg;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_request(op, need, seg);
   endtask

   // Drop start, wait for every owed result, then let the block go quiet
   task automatic settle();
      start <= 1'b0;
      while (ledger.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Random sender gap, taken one time in four, unless idling is off
   task automatic pace(bit quiet);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, bit [SIZE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      ledger.write_register(idx, value);
   endtask

   // Program all eight class registers from layout_size and layout_count
   task automatic load_layout();
      write_csr(REG_SIZE_A, layout_size[0]);
      write_csr(REG_COUNT_A, layout_count[0]);
      write_csr(REG_SIZE_B, layout_size[1]);
      write_csr(REG_COUNT_B, layout_count[1]);
      write_csr(REG_SIZE_C, layout_size[2]);
      write_csr(REG_COUNT_C, layout_count[2]);
      write_csr(REG_SIZE_D, layout_size[3]);
      write_csr(REG_COUNT_D, layout_count[3]);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed traffic: sizes near class sizes, releases of held segments
   task automatic send_random();
      op_type          op;
      bit [SIZE_W-1:0] need;
      bit [SEG_W-1:0]  seg;
      int              pick;
      int              cls;
      int              h;
      need = SIZE_W'($urandom);
      seg = SEG_W'($urandom);
      if ($urandom_range(0, 99) < 55) begin
         op = OP_ALLOC;
         cls = $urandom_range(0, NUM_CLASSES - 1);
         pick = $urandom_range(0, 9);
         if (pick < 4) need = ledger.class_size[cls];
         else if (pick < 6) need = ledger.class_size[cls] - SIZE_W'($urandom_range(0, 3));
         else if (pick < 8) need = ledger.class_size[cls] + 1'b1;
         else if (pick == 8) need = '0;
      end else begin
         op = OP_RELEASE;
         pick = $urandom_range(0, 99);
         h = ledger.held_segment();
         if (pick < 65 && h >= 0) seg = SEG_W'(h);
         else if (pick < 85 && ledger.seg_total > 0)
            seg = SEG_W'($urandom_range(0, ledger.seg_total - 1));
      end
      send_request(op, need, seg);
   endtask

   initial begin
      int unsigned acc;
      int unsigned cnt;
      bit          quiet_run;
      ledger = new();
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_ALLOC;
      req_request_size = '0;
      req_release_seg = '0;
      csr_write_enable = 1'b0;
      csr_index = REG_SIZE_A;
      csr_write_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset layout: one class of 100 segments; edges of size, beyond-total and full-class releases
      send_request(OP_ALLOC, '0, 8'hFF);                     pace(1'b0);
      send_request(OP_ALLOC, SIZE_A_RESET, '0);              pace(1'b0);
      send_request(OP_ALLOC, SIZE_A_RESET + 1'b1, '0);       pace(1'b0);
      send_request(OP_ALLOC, '1, '1);                        pace(1'b0);
      send_request(OP_RELEASE, '1, 8'd255);                  pace(1'b0);
      send_request(OP_RELEASE, '0, 8'd100);                  pace(1'b0);
      send_request(OP_RELEASE, '1, 8'd0);                    pace(1'b0);
      send_request(OP_RELEASE, '0, 8'd1);                    pace(1'b0);
      send_request(OP_RELEASE, '0, 8'd50);
      settle();

      // Out-of-order sizes, an empty class and an oversized last class
      layout_size = '{SIZE_W'(10), SIZE_W'(1000), SIZE_W'(5), '1};
      layout_count = '{SIZE_W'(2), SIZE_W'(0), SIZE_W'(3), SIZE_W'(300)};
      load_layout();
      send_request(OP_ALLOC, SIZE_W'(10), '0);               pace(1'b0);
      send_request(OP_ALLOC, SIZE_W'(10), '1);               pace(1'b0);
      send_request(OP_ALLOC, SIZE_W'(10), '0);               pace(1'b0);
      send_request(OP_ALLOC, SIZE_W'(3), '0);                pace(1'b0);
      send_request(OP_ALLOC, '1, '0);                        pace(1'b0);
      send_request(OP_RELEASE, '1, 8'd1);                    pace(1'b0);
      send_request(OP_RELEASE, '0, 8'd0);                    pace(1'b0);
      send_request(OP_RELEASE, '0, 8'd0);                    pace(1'b0);
      send_request(OP_RELEASE, '0, 8'd255);                  pace(1'b0);
      send_request(OP_RELEASE, '0, 8'd3);                    pace(1'b0);
      send_request(OP_RELEASE, '0, 8'd4);                    pace(1'b0);
      send_request(OP_ALLOC, '0, 8'hFF);

      // Random phases, each under a fresh layout; the last phase runs without gaps
      for (int phase = 0; phase < 9; phase++) begin
         settle();
         acc = $urandom_range(0, 1000);
         for (int c = 0; c < NUM_CLASSES; c++) begin
            // reversed order in phase 3 to check register-order search
            layout_size[(phase == 3) ? NUM_CLASSES - 1 - c : c] = SIZE_W'(acc);
            acc += (phase % 2) ? $urandom_range(0, 32'h1FFF_FFFF) : $urandom_range(0, 60);
            cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 300) : $urandom_range(0, 9);
            case (phase)
               0: begin
                  cnt = 0;
                  layout_size[c] = SIZE_W'($urandom);
               end
               1: cnt = (c == 0) ? 511 : $urandom_range(256, 511);
               2: begin
                  cnt = 1;
                  layout_size[c] = (c == NUM_CLASSES - 1) ? '1 : SIZE_W'(c);
               end
               default: ;
            endcase
            layout_count[c] = {(SIZE_W - CNT_W)'($urandom), CNT_W'(cnt)};
         end
         if (phase == 1) layout_size[0] = '1;
         if (phase == 8) layout_size[NUM_CLASSES - 1] = '1;
         load_layout();
         quiet_run = 1'b0;
         for (int n = 0; n < 140; n++) begin
            if (n % 20 == 0) quiet_run = ($urandom_range(0, 2) == 0);
            send_random();
            // once, hold off until every result is back
            if (phase == 4 && n == 70) settle();
            else pace(phase == 8 || quiet_run);
         end
      end

      settle();
      if (ledger.failures == 0 && ledger.owed.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
